FILE: sv/fkvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fkvt_pkg;

    // Byte roles
    localparam logic [1:0] ROLE_NONE  = 2'd0;
    localparam logic [1:0] ROLE_KEY   = 2'd1;
    localparam logic [1:0] ROLE_VALUE = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_OK       = 4'd0;
    localparam logic [3:0] ERR_NOBRACE  = 4'd1;
    localparam logic [3:0] ERR_EARLYEND = 4'd2;
    localparam logic [3:0] ERR_UNBAL    = 4'd3;
    localparam logic [3:0] ERR_QUOTE    = 4'd4;
    localparam logic [3:0] ERR_KEYCHAR  = 4'd5;
    localparam logic [3:0] ERR_COLON    = 4'd6;
    localparam logic [3:0] ERR_BETWEEN  = 4'd7;
    localparam logic [3:0] ERR_STUCK    = 4'd8;

    // Structural bytes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic [1:0] role;
        logic [7:0] out_ch;
        logic       pair_done;
        logic       object_done;
        logic [3:0] err;
    } result_t;

    // ASCII letters and digits only
    function automatic logic is_alnum(input logic [7:0] c);
        is_alnum = (c >= 8'h30 && c <= 8'h39) ||
                   (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

`default_nettype wire

FILE: sv/flat_key_value_object_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Width  Contents
// s_*       in         8      s_tdata[7:0] = ch, one text byte per request
// m_*       out        16+2+1 out_ch, pair_done, err in m_tdata;
//                             role on m_tuser; object_done on m_tlast
//
// One byte per cycle sustained while m_tready stays high: each byte goes from
// the input register through the parser step logic into the result register,
// whose valid flag drives m_tvalid.
// Reset (rst_n low) returns the parser to idle with the quote flag clear;
// an error stays latched until the next reset.
// A stalled m_tready holds the result; s_tready stays high while the input
// register is empty or its byte can move into the result register.
module flat_key_value_object_tokenizer (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch

    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,   // [7:0] out_ch, [8] pair_done, [12:9] err,
                                        // [15:13] zero
    output      logic [1:0]  m_tuser,   // [1:0] role
    output      logic        m_tlast    // object_done
);
    import fkvt_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] ch_reg;
    logic       out_valid_reg, out_valid_next;
    logic       advance;
    logic       step_en;
    result_t    res;

    // advance when the result register is free or being drained this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (step_en)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (step_en)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the byte on every accepted request; no reset on payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            ch_reg <= s_tdata;
    end

    // parse state and result register
    fkvt_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .ch      (ch_reg),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res.err, res.pair_done, res.out_ch};
    assign m_tuser  = res.role;
    assign m_tlast  = res.object_done;

endmodule

`default_nettype wire

FILE: sv/fkvt_core.sv
`timescale 1ns / 1ps
`default_nettype none

module fkvt_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step_en,
    input  wire logic [7:0]        ch,
    output fkvt_pkg::result_t      res
);
    import fkvt_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_KEYWAIT  = 3'd1,
        PH_KEY      = 3'd2,
        PH_COLON    = 3'd3,
        PH_VALSTART = 3'd4,
        PH_VALUE    = 3'd5,
        PH_NEXT     = 3'd6,
        PH_ERROR    = 3'd7
    } phase_t;

    phase_t  phase_reg, phase_next;
    logic    quoted_reg, quoted_next;
    result_t res_reg, res_next;

    logic [1:0] role;
    logic       pair;
    logic       obj;
    logic [3:0] err;
    phase_t     phase_step;

    always_comb
    begin
        role        = ROLE_NONE;
        pair        = 1'b0;
        obj         = 1'b0;
        err         = ERR_OK;
        phase_step  = phase_reg;
        quoted_next = quoted_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (ch == CH_LBRACE)
                    phase_step = PH_KEYWAIT;
                else if (ch != CH_SPACE)
                    err = ERR_NOBRACE;
            end
            PH_KEYWAIT:
            begin
                if (ch == CH_NUL)
                    err = ERR_EARLYEND;
                else if (ch == CH_QUOTE)
                begin
                    quoted_next = 1'b1;
                    phase_step  = PH_KEY;
                end
                else if (is_alnum(ch))
                begin
                    role       = ROLE_KEY;
                    phase_step = PH_KEY;
                end
                else
                    err = ERR_KEYCHAR;
            end
            PH_KEY:
            begin
                if (ch == CH_NUL)
                    err = ERR_EARLYEND;
                else if (ch == CH_QUOTE)
                begin
                    if (quoted_reg)
                    begin
                        quoted_next = 1'b0;
                        phase_step  = PH_COLON;
                    end
                    else
                        err = ERR_QUOTE;
                end
                else if (ch == CH_COLON)
                begin
                    if (quoted_reg)
                        err = ERR_UNBAL;
                    else
                        phase_step = PH_VALSTART;
                end
                else if (is_alnum(ch))
                    role = ROLE_KEY;
                else
                    err = ERR_KEYCHAR;
            end
            PH_COLON:
            begin
                if (ch == CH_COLON)
                    phase_step = PH_VALSTART;
                else
                    err = ERR_COLON;
            end
            PH_VALSTART, PH_VALUE:
            begin
                if (ch == CH_NUL)
                    err = ERR_EARLYEND;
                else if (ch == CH_QUOTE)
                begin
                    if (phase_reg == PH_VALSTART)
                    begin
                        quoted_next = 1'b1;
                        phase_step  = PH_VALUE;
                    end
                    else if (quoted_reg)
                    begin
                        quoted_next = 1'b0;
                        pair        = 1'b1;
                        phase_step  = PH_NEXT;
                    end
                    else
                        err = ERR_QUOTE;
                end
                else if (ch == CH_COMMA)
                begin
                    if (quoted_reg)
                        role = ROLE_VALUE;
                    else
                    begin
                        pair       = 1'b1;
                        phase_step = PH_KEYWAIT;
                    end
                end
                else if (ch == CH_RBRACE)
                begin
                    if (quoted_reg)
                        err = ERR_UNBAL;
                    else
                    begin
                        pair       = 1'b1;
                        obj        = 1'b1;
                        phase_step = PH_IDLE;
                    end
                end
                else
                    role = ROLE_VALUE;
            end
            PH_NEXT:
            begin
                if (ch == CH_COMMA)
                    phase_step = PH_KEYWAIT;
                else if (ch == CH_RBRACE)
                begin
                    obj        = 1'b1;
                    phase_step = PH_IDLE;
                end
                else
                    err = ERR_BETWEEN;
            end
            default:
                err = ERR_STUCK;
        endcase

        // any error clears the other outputs and locks the parser
        if (err != ERR_OK)
        begin
            role       = ROLE_NONE;
            pair       = 1'b0;
            obj        = 1'b0;
            phase_next = PH_ERROR;
        end
        else
            phase_next = phase_step;

        res_next.role        = role;
        res_next.out_ch      = (role != ROLE_NONE) ? ch : 8'h00;
        res_next.pair_done   = pair;
        res_next.object_done = obj;
        res_next.err         = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            quoted_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            quoted_reg <= quoted_next;
            res_reg    <= res_next;
        end
    end

    assign res = res_reg;

    a_stuck: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && phase_reg == PH_ERROR |=> res_reg.err == ERR_STUCK && phase_reg == PH_ERROR)
        else $error("error state left or not reported as stuck");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> res_reg.err == ERR_OK ||
            (res_reg.role == ROLE_NONE && !res_reg.pair_done && !res_reg.object_done &&
             phase_reg == PH_ERROR))
        else $error("error result carries other fields or parser not locked");

    a_obj_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> !res_reg.object_done || (phase_reg == PH_IDLE && !quoted_reg))
        else $error("object end without returning to idle");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(phase_reg) && $stable(quoted_reg))
        else $error("parser state moved without a step");

    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> res_reg.role != ROLE_NONE || res_reg.out_ch == 8'h00)
        else $error("byte echoed on a structural result");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import fkvt_pkg::*;

    // Parser phases, kept locally since the package does not export them
    typedef enum logic [2:0] {
        SEEK_BRACE,   // idle, waiting for the opening brace
        WANT_KEY,     // first byte of a key
        IN_KEY,       // inside a key
        WANT_COLON,   // colon after a quoted key
        VAL_OPEN,     // value start; unquoted values stay here
        IN_QVAL,      // inside a quoted value or quoted part
        WANT_SEP,     // comma or closing brace
        JAMMED        // error latched until reset
    } parse_phase_t;

    // One text byte with an optional hand-written expectation
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        result_t    want;
    } text_row_t;

    localparam int N_DIRECTED = 25;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    parse_phase_t phase = SEEK_BRACE;
    logic         in_quotes = 1'b0;

    text_row_t directed_rows [N_DIRECTED];
    text_row_t text_bytes [$];
    result_t   expected_tokens [$];
    result_t   seen_tok;
    result_t   want_tok;
    int        mismatches = 0;
    bit        calm = 1'b0;

    flat_key_value_object_tokenizer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ASCII letters and digits; folding bit 5 maps lower case onto upper case
    function automatic bit is_word_char(input logic [7:0] c);
        logic [7:0] up;
        up = c & 8'hDF;
        return (c >= 8'h30 && c <= 8'h39) || (up >= 8'h41 && up <= 8'h5A);
    endfunction

    // Advance the parser by one byte and return the token it reports
    function automatic result_t tokenize_byte(input logic [7:0] c);
        result_t      r;
        logic [3:0]   fault;
        parse_phase_t ph;
        r     = '0;
        fault = ERR_OK;
        ph    = phase;
        case (ph)
            SEEK_BRACE:
            begin
                if (c == CH_LBRACE)
                    phase = WANT_KEY;
                else if (c != CH_SPACE)
                    fault = ERR_NOBRACE;
            end
            WANT_KEY:
            begin
                if (c == CH_NUL)
                    fault = ERR_EARLYEND;
                else if (c == CH_QUOTE)
                begin
                    in_quotes = 1'b1;
                    phase     = IN_KEY;
                end
                else if (is_word_char(c))
                begin
                    r.role = ROLE_KEY;
                    phase  = IN_KEY;
                end
                else
                    fault = ERR_KEYCHAR;
            end
            IN_KEY:
            begin
                if (c == CH_NUL)
                    fault = ERR_EARLYEND;
                else if (c == CH_QUOTE)
                begin
                    if (in_quotes)
                    begin
                        in_quotes = 1'b0;
                        phase     = WANT_COLON;
                    end
                    else
                        fault = ERR_QUOTE;
                end
                else if (c == CH_COLON)
                begin
                    if (in_quotes)
                        fault = ERR_UNBAL;
                    else
                        phase = VAL_OPEN;
                end
                else if (is_word_char(c))
                    r.role = ROLE_KEY;
                else
                    fault = ERR_KEYCHAR;
            end
            WANT_COLON:
            begin
                if (c == CH_COLON)
                    phase = VAL_OPEN;
                else
                    fault = ERR_COLON;
            end
            VAL_OPEN, IN_QVAL:
            begin
                if (c == CH_NUL)
                    fault = ERR_EARLYEND;
                else if (c == CH_QUOTE)
                begin
                    if (ph == VAL_OPEN)
                    begin
                        in_quotes = 1'b1;
                        phase     = IN_QVAL;
                    end
                    else if (in_quotes)
                    begin
                        in_quotes   = 1'b0;
                        r.pair_done = 1'b1;
                        phase       = WANT_SEP;
                    end
                    else
                        fault = ERR_QUOTE;
                end
                else if (c == CH_COMMA)
                begin
                    if (in_quotes)
                        r.role = ROLE_VALUE;
                    else
                    begin
                        r.pair_done = 1'b1;
                        phase       = WANT_KEY;
                    end
                end
                else if (c == CH_RBRACE)
                begin
                    if (in_quotes)
                        fault = ERR_UNBAL;
                    else
                    begin
                        r.pair_done   = 1'b1;
                        r.object_done = 1'b1;
                        phase         = SEEK_BRACE;
                    end
                end
                else
                    r.role = ROLE_VALUE;
            end
            WANT_SEP:
            begin
                if (c == CH_COMMA)
                    phase = WANT_KEY;
                else if (c == CH_RBRACE)
                begin
                    r.object_done = 1'b1;
                    phase         = SEEK_BRACE;
                end
                else
                    fault = ERR_BETWEEN;
            end
            default:
                fault = ERR_STUCK;
        endcase
        // An error clears every other field and latches the parser
        if (fault != ERR_OK)
        begin
            r       = '0;
            r.err   = fault;
            phase   = JAMMED;
        end
        else if (r.role != ROLE_NONE)
            r.out_ch = c;
        return r;
    endfunction

    task automatic add_byte(input logic [7:0] c);
        text_bytes.insert(text_bytes.size(), {c, 1'b0, 16'h0000});
    endtask

    function automatic logic [7:0] pick_key_char();
        int k;
        k = $urandom_range(0, 61);
        if (k < 10)
            return 8'h30 + 8'(k);        // digits
        else if (k < 36)
            return 8'h41 + 8'(k - 10);   // upper case
        else
            return 8'h61 + 8'(k - 36);   // lower case
    endfunction

    // Any nonzero byte that keeps the value going; a comma is only safe in quotes
    function automatic logic [7:0] pick_value_byte(input bit quoted_part);
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CH_QUOTE || b == CH_RBRACE || (!quoted_part && b == CH_COMMA));
        return b;
    endfunction

    // Append one well-formed object with random keys, value styles and content
    task automatic compose_object();
        int n_pairs;
        int style;
        n_pairs = $urandom_range(1, 4);
        repeat ($urandom_range(0, 2)) add_byte(CH_SPACE);
        add_byte(CH_LBRACE);
        for (int p = 0; p < n_pairs; p++)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                add_byte(CH_QUOTE);
                repeat ($urandom_range(1, 6)) add_byte(pick_key_char());
                add_byte(CH_QUOTE);
            end
            else
                repeat ($urandom_range(1, 6)) add_byte(pick_key_char());
            add_byte(CH_COLON);
            style = $urandom_range(0, 2);
            if (style == 0)
            begin
                add_byte(CH_QUOTE);
                repeat ($urandom_range(0, 6)) add_byte(pick_value_byte(1'b1));
                add_byte(CH_QUOTE);
            end
            else
            begin
                repeat ($urandom_range(0, 5)) add_byte(pick_value_byte(1'b0));
                // a quote inside an unquoted value opens a quoted part
                if (style == 2)
                begin
                    add_byte(CH_QUOTE);
                    repeat ($urandom_range(0, 4)) add_byte(pick_value_byte(1'b1));
                    add_byte(CH_QUOTE);
                end
            end
            add_byte((p == n_pairs - 1) ? CH_RBRACE : CH_COMMA);
        end
    endtask

    // Append a broken object that ends in one randomly chosen error, then
    // noise that must all come back as stuck
    task automatic compose_failure();
        logic [3:0] kind;
        kind = 4'($urandom_range(ERR_NOBRACE, ERR_BETWEEN));
        case (kind)
            ERR_NOBRACE:
                add_byte(CH_NUL);
            ERR_EARLYEND:
            begin
                add_byte(CH_LBRACE);
                add_byte(CH_NUL);
            end
            ERR_UNBAL:
            begin
                add_byte(CH_LBRACE);
                add_byte(CH_QUOTE);
                add_byte("a");
                add_byte(CH_COLON);
            end
            ERR_QUOTE:
            begin
                add_byte(CH_LBRACE);
                add_byte("a");
                add_byte(CH_QUOTE);
            end
            ERR_KEYCHAR:
            begin
                add_byte(CH_LBRACE);
                add_byte("-");
            end
            ERR_COLON:
            begin
                add_byte(CH_LBRACE);
                add_byte(CH_QUOTE);
                add_byte("a");
                add_byte(CH_QUOTE);
                add_byte("x");
            end
            default:
            begin
                add_byte(CH_LBRACE);
                add_byte("a");
                add_byte(CH_COLON);
                add_byte(CH_QUOTE);
                add_byte("v");
                add_byte(CH_QUOTE);
                add_byte("x");
            end
        endcase
        repeat (12) add_byte(8'($urandom_range(0, 255)));
    endtask

    // Directed walk through one session: quoted and unquoted keys, quoted and
    // unquoted values, a comma inside quotes, high bytes, a quoted part inside
    // an unquoted value, an empty value closed by the brace. Rows with a
    // hand-written expectation carry typed = 1.
    initial
    begin
        directed_rows = '{
            {CH_SPACE,  1'b1, ROLE_NONE,  CH_NUL, 1'b0, 1'b0, ERR_OK},  // skipped in idle
            {CH_LBRACE, 1'b1, ROLE_NONE,  CH_NUL, 1'b0, 1'b0, ERR_OK},
            {CH_QUOTE,  1'b0, 16'h0000},                                // quoted key opens
            {"A",       1'b0, 16'h0000},
            {"z",       1'b0, 16'h0000},
            {CH_QUOTE,  1'b0, 16'h0000},
            {CH_COLON,  1'b0, 16'h0000},
            {CH_QUOTE,  1'b0, 16'h0000},                                // quoted value opens
            {CH_COMMA,  1'b0, 16'h0000},                                // comma is data here
            {8'hFF,     1'b1, ROLE_VALUE, 8'hFF,  1'b0, 1'b0, ERR_OK},
            {8'h80,     1'b0, 16'h0000},
            {CH_QUOTE,  1'b0, 16'h0000},                                // pair done
            {CH_COMMA,  1'b0, 16'h0000},
            {"0",       1'b0, 16'h0000},                                // unquoted key
            {"9",       1'b0, 16'h0000},
            {CH_COLON,  1'b0, 16'h0000},
            {8'h01,     1'b0, 16'h0000},                                // unquoted value
            {CH_QUOTE,  1'b0, 16'h0000},                                // quoted part opens
            {CH_LBRACE, 1'b0, 16'h0000},
            {CH_QUOTE,  1'b0, 16'h0000},
            {CH_RBRACE, 1'b1, ROLE_NONE,  CH_NUL, 1'b0, 1'b1, ERR_OK},  // object closes
            {CH_LBRACE, 1'b0, 16'h0000},
            {"k",       1'b0, 16'h0000},
            {CH_COLON,  1'b0, 16'h0000},
            {CH_RBRACE, 1'b0, 16'h0000}                                 // empty value
        };
    end

    // Release reset once the clock runs; it is never asserted again
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Request side: build the whole text, then feed it with random gaps.
    // The prediction is taken at the edge where the request is accepted.
    initial
    begin : feed
        text_row_t item;
        result_t   got;
        s_tvalid = 1'b0;
        s_tdata  = CH_NUL;

        wait (rst_n);
        for (int i = 0; i < N_DIRECTED; i++)
            text_bytes.insert(text_bytes.size(), directed_rows[i]);
        while (text_bytes.size() < 1830)
            compose_object();
        // the error is sticky and reset comes only once, so it goes last
        compose_failure();

        @(posedge clk);
        for (int i = 0; i < text_bytes.size(); i++)
        begin
            item = text_bytes[i];
            // the final stretch runs with no idling on either side
            if (i >= text_bytes.size() - 200)
                calm = 1'b1;
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= item.ch;
            do
                @(posedge clk);
            while (!s_tready);
            got = tokenize_byte(item.ch);
            expected_tokens.insert(expected_tokens.size(), item.typed ? item.want : got);
        end
        s_tvalid <= 1'b0;

        // drain, then wait on to catch stray results
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result side: random stall bursts until the final stretch
    initial
    begin : drain
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(0, 12)) @(posedge clk);
        end
    end

    // Compare each accepted result with the oldest expected token
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_tok.role        = m_tuser;
            seen_tok.out_ch      = m_tdata[7:0];
            seen_tok.pair_done   = m_tdata[8];
            seen_tok.object_done = m_tlast;
            seen_tok.err         = m_tdata[12:9];
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected result: expected none, got m_tdata %h m_tuser %h m_tlast %b",
                       m_tdata, m_tuser, m_tlast);
                mismatches++;
            end
            else
            begin
                want_tok = expected_tokens.pop_front();
                if (seen_tok.role !== want_tok.role)
                begin
                    $error("role: expected %0d, got %0d", want_tok.role, seen_tok.role);
                    mismatches++;
                end
                if (seen_tok.out_ch !== want_tok.out_ch)
                begin
                    $error("out_ch: expected %h, got %h", want_tok.out_ch, seen_tok.out_ch);
                    mismatches++;
                end
                if (seen_tok.pair_done !== want_tok.pair_done)
                begin
                    $error("pair_done: expected %b, got %b",
                           want_tok.pair_done, seen_tok.pair_done);
                    mismatches++;
                end
                if (seen_tok.object_done !== want_tok.object_done)
                begin
                    $error("object_done: expected %b, got %b",
                           want_tok.object_done, seen_tok.object_done);
                    mismatches++;
                end
                if (seen_tok.err !== want_tok.err)
                begin
                    $error("err: expected %0d, got %0d", want_tok.err, seen_tok.err);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
